[rtl/kadr_pkg.sv]
// Package for the knob ADC deadband reporter: field widths, register
// indexes, reset values and the constants of the percent conversion.
// No dependencies.
package kadr_pkg;

    localparam int CHANNELS_DEF = 6;
    localparam int ADC_MAX      = 1023;

    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 10;
    localparam int DB_W     = 10;
    localparam int THR_W    = 10;
    localparam int BOOST_W  = 6;
    localparam int VAL_W    = 12;   // stored value, two's complement, -1 .. 1086
    localparam int PCT_W    = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [DB_W-1:0]    DEADBAND_RST = DB_W'(5);
    localparam logic [THR_W-1:0]   BOOST_THR_RST = THR_W'(511);
    localparam logic [BOOST_W-1:0] BOOST_AMT_RST = BOOST_W'(10);

    // Division by ADC_MAX is a multiplication by a rounded-up reciprocal.
    // With the shift below the error stays under one step of the quotient
    // for every value the stored register can hold.
    localparam int      PCT_SHIFT = 28;
    localparam int      PCT_MUL_W = 25;
    localparam longint  PCT_MULT_L =
        (64'd100 * (64'd1 << PCT_SHIFT) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX);
    localparam logic [PCT_MUL_W-1:0] PCT_MULT = PCT_MUL_W'(PCT_MULT_L);
    localparam logic [PCT_W-1:0]     PCT_MAX  = PCT_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND  = 2'd0,
        CFG_BOOST_THR = 2'd1,
        CFG_BOOST_AMT = 2'd2
    } t_cfg_idx;

endpackage

[rtl/knob_adc_deadband_reporter.sv]
// Top level of the knob ADC deadband reporter: per-channel change detection
// with a deadband and a boost above a threshold. Depends on kadr_pkg and kadr_pct.
//
// Usage:
//   s_axis carries one reading per beat: tdata holds channel and sample,
//   tuser holds the read-error flag. m_axis carries one report per beat
//   with channel and percent. Readings that cause no report are absorbed.
//   The configuration channel writes deadband, boost threshold and boost
//   amount by index; it is always ready and is meant to be used while idle.
//   A reading accepted on s_axis passes the input, decision and output
//   registers before its report shows on m_axis. Throughput: one reading
//   per cycle unless a receiver stall backs up the pipeline; the per-
//   channel compare and state write happen as a reading leaves the input
//   register, so the next reading of the same channel sees the update at
//   once. The percent multiply sits between decision and output register.
//   Reset clears all channel seen flags and restores the register defaults.
//   When the receiver stalls, the output register holds its beat and the
//   pipeline keeps filling its two inner stages, then deasserts
//   s_axis_tready; bubbles collapse so no beat is lost.
module knob_adc_deadband_reporter
    import kadr_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [2:0] channel, [12:3] sample, rest zero
    input  logic                  s_axis_tuser,  // [0] read_error
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [2:0] event_channel, [9:3] percent
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > CH_W) ? IDX_W : CH_W;

    // Configuration registers.
    logic [DB_W-1:0]    r_deadband;
    logic [THR_W-1:0]   r_boost_thr;
    logic [BOOST_W-1:0] r_boost_amt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband  <= DEADBAND_RST;
            r_boost_thr <= BOOST_THR_RST;
            r_boost_amt <= BOOST_AMT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEADBAND:  r_deadband  <= i_cfg_data[DB_W-1:0];
                CFG_BOOST_THR: r_boost_thr <= i_cfg_data[THR_W-1:0];
                CFG_BOOST_AMT: r_boost_amt <= i_cfg_data[BOOST_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: each stage advances when the next has room.
    logic r_s0_valid, r_s1_valid, r_s1_report, r_out_valid;
    logic out_ready, s1_ready, s0_ready, s0_adv;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign s1_ready      = !r_s1_valid || !r_s1_report || out_ready;
    assign s0_ready      = !r_s0_valid || s1_ready;
    assign s0_adv        = r_s0_valid && s1_ready;
    assign s_axis_tready = s0_ready;

    // Input register.
    logic [CH_W-1:0]     r_s0_ch;
    logic [SAMPLE_W-1:0] r_s0_sample;
    logic                r_s0_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && s_axis_tvalid) begin
            r_s0_ch     <= s_axis_tdata[CH_W-1:0];
            r_s0_sample <= s_axis_tdata[CH_W+SAMPLE_W-1:CH_W];
            r_s0_err    <= s_axis_tuser;
        end
    end

    // Per-channel state.
    logic signed [VAL_W-1:0] r_last [CHANNELS];
    logic [CHANNELS-1:0]     r_seen;

    logic [EXT_W-1:0]        ch_ext;
    logic [IDX_W-1:0]        ch_idx;
    logic                    in_range;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] last;
    logic signed [VAL_W:0]   diff;
    logic [VAL_W:0]          abs_diff;
    logic                    seen;
    logic                    report;

    assign ch_ext   = EXT_W'(r_s0_ch);
    assign ch_idx   = ch_ext[IDX_W-1:0];
    assign in_range = 32'(r_s0_ch) < 32'(CHANNELS);
    assign last     = r_last[ch_idx];
    assign seen     = r_seen[ch_idx];

    always_comb begin
        if (r_s0_err) begin
            value = -VAL_W'(1);
        end else if (r_s0_sample > r_boost_thr) begin
            value = VAL_W'(r_s0_sample) + VAL_W'(r_boost_amt);
        end else begin
            value = VAL_W'(r_s0_sample);
        end
        diff = (VAL_W+1)'(value) - (VAL_W+1)'(last);
        abs_diff = diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
        if (!in_range) begin
            report = 1'b0;
        end else if (!seen) begin
            // First reading of a channel is always reported, errors too.
            report = 1'b1;
        end else if (r_s0_err || value == last) begin
            report = 1'b0;
        end else begin
            report = abs_diff >= (VAL_W+1)'(r_deadband);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (s0_adv && report) begin
            r_seen[ch_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_adv && report) begin
            r_last[ch_idx] <= value;
        end
    end

    // Decision register.
    logic [CH_W-1:0]         r_s1_ch;
    logic signed [VAL_W-1:0] r_s1_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s1_report <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid  <= r_s0_valid;
            r_s1_report <= r_s0_valid && report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_adv) begin
            r_s1_ch    <= r_s0_ch;
            r_s1_value <= value;
        end
    end

    // Percent conversion and output register.
    logic [PCT_W-1:0] percent;
    logic [CH_W-1:0]  r_out_ch;
    logic [PCT_W-1:0] r_out_pct;

    kadr_pct u_pct (
        .i_value   (r_s1_value),
        .o_percent (percent)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid && r_s1_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid && r_s1_report) begin
            r_out_ch  <= r_s1_ch;
            r_out_pct <= percent;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out_pct, r_out_ch});

endmodule

[rtl/kadr_pct.sv]
// Converts a stored knob value into a position of 0 to 100 percent.
// Depends on kadr_pkg for widths and the reciprocal constant.
module kadr_pct
    import kadr_pkg::*;
(
    input  logic signed [VAL_W-1:0] i_value,
    output logic        [PCT_W-1:0] o_percent
);

    localparam int MAG_W  = VAL_W - 1;
    localparam int PROD_W = MAG_W + PCT_MUL_W;

    logic [PROD_W-1:0]           prod;
    logic [PROD_W-PCT_SHIFT-1:0] quot;

    assign prod = PROD_W'(i_value[MAG_W-1:0]) * PROD_W'(PCT_MULT);
    assign quot = prod[PROD_W-1:PCT_SHIFT];

    always_comb begin
        if (i_value <= 0) begin
            o_percent = '0;
        end else if (quot > (PROD_W-PCT_SHIFT)'(PCT_MAX)) begin
            // A boosted value can exceed full scale.
            o_percent = PCT_MAX;
        end else begin
            o_percent = quot[PCT_W-1:0];
        end
    end

endmodule
